@@ rtl/multi_mode_string_hash_defines.svh @@
// assertion macros shared by the string hash rtl
`ifndef MULTI_MODE_STRING_HASH_DEFINES_SVH
`define MULTI_MODE_STRING_HASH_DEFINES_SVH

`ifndef ASSERT_OFF
// implication or plain property, checked on every rising edge out of reset
`define MMSH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("mmsh assertion failed");
// condition that must never be seen out of reset
`define MMSH_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("mmsh forbidden condition seen");
`else
`define MMSH_ASSERT(lbl, clk, rstn, prop)
`define MMSH_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ rtl/mmsh_pkg.sv @@
// shared types, constants and start-value function of the string hash
package mmsh_pkg;

    localparam int HASH_BITS  = 32;
    localparam int MODE_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int KEY_LEN_W  = 16;

    // scheme codes
    localparam logic [MODE_W-1:0] MODE_AP   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_BP   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_JS   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_RS   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DEK  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DJB  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ELF  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_FNV  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_PJW  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_BKDR = 4'd9;
    localparam logic [MODE_W-1:0] MODE_SDBM = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_OFFSET = 2'd1;

    // scheme constants
    localparam logic [HASH_BITS-1:0] AP_START    = 32'hAAAA_AAAA;
    localparam logic [HASH_BITS-1:0] JS_START    = 32'd1315423911;
    localparam logic [HASH_BITS-1:0] DJB_START   = 32'd5381;
    localparam logic [HASH_BITS-1:0] RS_A        = 32'd378551;
    localparam logic [HASH_BITS-1:0] RS_B_START  = 32'd63689;
    localparam logic [HASH_BITS-1:0] FNV_MULT    = 32'h811C_9DC5;
    localparam logic [HASH_BITS-1:0] BKDR_SEED   = 32'd131;
    localparam logic [HASH_BITS-1:0] HIGH_NIBBLE = 32'hF000_0000;

    typedef logic [HASH_BITS-1:0] hash_t;

    // running state carried from byte to byte within a key
    typedef struct packed {
        hash_t hash;
        logic  odd;
        hash_t rs_mult;
    } fold_state_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        hash_t             offset;
    } cfg_t;

    // value a key starts from under each scheme
    function automatic hash_t start_value(input logic [MODE_W-1:0] mode,
                                          input logic [KEY_LEN_W-1:0] len);
        hash_t v;
        case (mode)
            MODE_AP:  v = AP_START;
            MODE_JS:  v = JS_START;
            MODE_DEK: v = {{(HASH_BITS-KEY_LEN_W){1'b0}}, len};
            MODE_DJB: v = DJB_START;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/mmsh_cfg.sv @@
// configuration register file: scheme select and result offset
module mmsh_cfg
    import mmsh_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HASH_BITS-1:0] cfg_data,
    output cfg_t                 cfg
);

    logic [MODE_W-1:0] mode_reg;
    hash_t             offset_reg;

    // writes are always accepted, cfg_ready is tied high
    assign cfg_ready = 1'b1;

    // register decode, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            offset_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HASH_MODE:     mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_RESULT_OFFSET: offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.mode   = mode_reg;
    assign cfg.offset = offset_reg;

endmodule

@@ rtl/mmsh_fold.sv @@
// one-byte fold of the running hash for every scheme
module mmsh_fold
    import mmsh_pkg::*;
(
    input  logic [MODE_W-1:0] mode,
    input  logic [7:0]        key_byte,
    input  fold_state_t       state_in,
    output fold_state_t       state_out
);

    hash_t h;
    hash_t c;
    hash_t ap_prod;
    hash_t rs_prod;
    hash_t fnv_prod;
    hash_t bkdr_prod;
    hash_t nib_sum;
    hash_t nib_top;
    hash_t nib_mix;
    hash_t next_hash;

    assign h = state_in.hash;
    assign c = {{(HASH_BITS-8){1'b0}}, key_byte};

    // products, each taken modulo 2^32
    assign ap_prod   = c * (h >> 3);
    assign rs_prod   = h * state_in.rs_mult;
    assign fnv_prod  = h * FNV_MULT;
    assign bkdr_prod = h * BKDR_SEED;

    // elf and pjw share the shift-add and top nibble fold
    assign nib_sum = (h << 4) + c;
    assign nib_top = nib_sum & HIGH_NIBBLE;
    assign nib_mix = nib_sum ^ (nib_top >> 24);

    // scheme select
    always_comb begin
        case (mode)
            MODE_AP: begin
                if (!state_in.odd) begin
                    next_hash = h ^ ((h << 7) ^ ap_prod);
                end else begin
                    next_hash = h ^ ~((h << 11) + (c ^ (h >> 5)));
                end
            end
            MODE_BP:   next_hash = (h << 7) ^ c;
            MODE_JS:   next_hash = h ^ ((h << 5) + c + (h >> 2));
            MODE_RS:   next_hash = rs_prod + c;
            MODE_DEK:  next_hash = ((h << 5) ^ (h >> 27)) ^ c;
            MODE_DJB:  next_hash = (h << 5) + h + c;
            MODE_ELF:  next_hash = nib_mix & ~nib_top;
            MODE_FNV:  next_hash = fnv_prod ^ c;
            MODE_PJW:  next_hash = nib_mix & ~HIGH_NIBBLE;
            MODE_BKDR: next_hash = bkdr_prod + c;
            MODE_SDBM: next_hash = c + (h << 6) + (h << 16) - h;
            default:   next_hash = h;
        endcase
    end

    // parity and rs multiplier advance on every byte, whatever the scheme
    assign state_out.hash    = next_hash;
    assign state_out.odd     = ~state_in.odd;
    assign state_out.rs_mult = state_in.rs_mult * RS_A;

endmodule

@@ rtl/multi_mode_string_hash.sv @@
// top level of the multi-scheme string hash engine
`include "multi_mode_string_hash_defines.svh"

// Key bytes enter one per transaction on the s_ channel; the hash of a key
// leaves on the m_ channel after its last byte, or at once for an empty key.
// One byte is folded per clock, so a byte may be accepted on every cycle while
// a key's finishing byte is not held back by a stalled m_ side; the limit is
// the combinational fold of the running hash (the rs scheme's 32x32 multiply
// sits in that loop). A byte passes an input register, the fold stage and
// then the offset adder stage, each of them registered, on its way out.
// Configuration writes are always accepted and must only be made while no
// key byte is in flight.
module multi_mode_string_hash
    import mmsh_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HASH_BITS-1:0] cfg_data,
    // key bytes
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_key_byte,
    input  logic [KEY_LEN_W-1:0] s_key_length,
    input  logic                 s_last_byte,
    input  logic                 s_empty_key,
    // hashes
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [HASH_BITS-1:0] m_hash_value
);

    cfg_t cfg;

    // input stage
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic [KEY_LEN_W-1:0] in_len_reg;
    logic                 in_last_reg;
    logic                 in_empty_reg;

    // running state
    fold_state_t state_reg;
    fold_state_t state_start;
    fold_state_t state_folded;
    logic        inside_reg;

    // raw hash stage
    logic  raw_valid_reg;
    hash_t raw_hash_reg;

    // output stage
    logic  out_valid_reg;
    hash_t out_hash_reg;

    logic  out_adv;
    logic  raw_ready;
    logic  raw_adv;
    logic  in_produces;
    logic  in_adv;
    hash_t start_hash;

    mmsh_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage handshakes, each stage frees as soon as its content moves on
    assign out_adv     = !out_valid_reg || m_ready;
    assign raw_adv     = raw_valid_reg && out_adv;
    assign raw_ready   = !raw_valid_reg || out_adv;
    assign in_produces = in_last_reg || in_empty_reg;
    assign in_adv      = in_valid_reg && (!in_produces || raw_ready);
    assign s_ready     = !in_valid_reg || in_adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_key_byte;
            in_len_reg   <= s_key_length;
            in_last_reg  <= s_last_byte;
            in_empty_reg <= s_empty_key;
        end
    end

    // reload at key start
    assign start_hash = start_value(cfg.mode, in_len_reg);

    always_comb begin
        if (inside_reg) begin
            state_start = state_reg;
        end else begin
            state_start.hash    = start_hash;
            state_start.odd     = 1'b0;
            state_start.rs_mult = RS_B_START;
        end
    end

    mmsh_fold u_fold (
        .mode      (cfg.mode),
        .key_byte  (in_byte_reg),
        .state_in  (state_start),
        .state_out (state_folded)
    );

    // running state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg        <= 1'b0;
            state_reg.hash    <= '0;
            state_reg.odd     <= 1'b0;
            state_reg.rs_mult <= RS_B_START;
        end else if (in_adv) begin
            if (in_empty_reg) begin
                inside_reg <= 1'b0;
            end else begin
                inside_reg <= !in_last_reg;
                state_reg  <= state_folded;
            end
        end
    end

    // raw hash stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_valid_reg <= 1'b0;
        end else if (raw_ready) begin
            raw_valid_reg <= in_adv && in_produces;
        end
    end

    always_ff @(posedge aclk) begin
        if (raw_ready && in_adv && in_produces) begin
            raw_hash_reg <= in_empty_reg ? start_hash : state_folded.hash;
        end
    end

    // output stage adds the offset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= raw_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (raw_adv) begin
            out_hash_reg <= raw_hash_reg + cfg.offset;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_hash_reg;

    // a new result only ever comes from a full raw stage
    `MMSH_ASSERT(a_out_from_raw, aclk, aresetn, $rose(out_valid_reg) |-> $past(raw_valid_reg))
    // an empty key always leaves the engine outside a key
    `MMSH_ASSERT(a_empty_clears, aclk, aresetn, (in_adv && in_empty_reg) |=> !inside_reg)
    // a held raw hash is not overwritten while the output stalls
    `MMSH_ASSERT(a_raw_holds, aclk, aresetn, (raw_valid_reg && !out_adv) |=> (raw_valid_reg && $stable(raw_hash_reg)))
    // a finishing byte never retires into a blocked raw stage
    `MMSH_ASSERT_NEVER(a_no_drop, aclk, aresetn, in_adv && in_produces && raw_valid_reg && !out_adv)

endmodule

@@ sim/mmsh_checker.sv @@
// scoreboard for the string hash: tracks register writes, predicts each key hash and compares
`timescale 1ns / 1ps

module mmsh_checker
    import mmsh_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HASH_BITS-1:0] cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [7:0]           s_key_byte,
    input  logic [KEY_LEN_W-1:0] s_key_length,
    input  logic                 s_last_byte,
    input  logic                 s_empty_key,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [HASH_BITS-1:0] m_hash_value,
    output int                   error_count,
    output int                   pending_hashes,
    output int                   hashes_checked,
    output int                   bytes_folded,
    output int                   empty_keys,
    output logic [15:0]          modes_seen
);

    // hashes still owed by the block, oldest first
    hash_t             owed_hashes[$];

    // shadow registers and running key state
    logic [MODE_W-1:0] shadow_mode;
    hash_t             shadow_offset;
    hash_t             key_hash;
    hash_t             rs_factor;
    logic              odd_byte;
    logic              mid_key;

    int                errors;
    int                checked;
    int                folded;
    int                empties;
    logic [15:0]       seen;

    // value each scheme starts a key from
    function automatic hash_t key_seed(input logic [MODE_W-1:0] mode,
                                       input logic [KEY_LEN_W-1:0] len);
        hash_t seed;
        case (mode)
            MODE_AP:  seed = AP_START;
            MODE_JS:  seed = JS_START;
            MODE_DEK: seed = hash_t'(len);
            MODE_DJB: seed = DJB_START;
            default:  seed = '0;
        endcase
        return seed;
    endfunction

    // one byte folded into the running hash, all arithmetic mod 2^32
    function automatic hash_t fold_key_byte(input logic [MODE_W-1:0] mode,
                                            input hash_t h,
                                            input logic [7:0] c,
                                            input logic odd,
                                            input hash_t rs);
        hash_t cw;
        hash_t top;
        hash_t acc;
        cw  = hash_t'(c);
        acc = h;
        case (mode)
            MODE_AP: begin
                if (!odd)
                    acc = h ^ ((h << 7) ^ (cw * (h >> 3)));
                else
                    acc = h ^ ~((h << 11) + (cw ^ (h >> 5)));
            end
            MODE_BP:   acc = (h << 7) ^ cw;
            MODE_JS:   acc = h ^ ((h << 5) + cw + (h >> 2));
            MODE_RS:   acc = (h * rs) + cw;
            MODE_DEK:  acc = ((h << 5) ^ (h >> 27)) ^ cw;
            MODE_DJB:  acc = (h << 5) + h + cw;
            MODE_ELF: begin
                acc = (h << 4) + cw;
                top = acc & HIGH_NIBBLE;
                if (top != '0)
                    acc = acc ^ (top >> 24);
                acc = acc & ~top;
            end
            MODE_FNV:  acc = (h * FNV_MULT) ^ cw;
            MODE_PJW: begin
                acc = (h << 4) + cw;
                top = acc & HIGH_NIBBLE;
                if (top != '0)
                    acc = (acc ^ (top >> 24)) & ~HIGH_NIBBLE;
            end
            MODE_BKDR: acc = (h * BKDR_SEED) + cw;
            MODE_SDBM: acc = cw + (h << 6) + (h << 16) - h;
            default:   acc = h;
        endcase
        return acc;
    endfunction

    always @(posedge aclk) begin
        hash_t want;
        hash_t sum;
        if (!aresetn) begin
            owed_hashes.delete();
            shadow_mode   = MODE_AP;
            shadow_offset = '0;
            key_hash      = '0;
            rs_factor     = RS_B_START;
            odd_byte      = 1'b0;
            mid_key       = 1'b0;
            errors        = 0;
            checked       = 0;
            folded        = 0;
            empties       = 0;
            seen          = '0;
        end else begin
            // result transaction against the oldest owed hash
            if (m_valid && m_ready) begin
                if (owed_hashes.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] hash %08h arrived with none owed", $realtime,
                                 m_hash_value);
                end else begin
                    want = owed_hashes.pop_front();
                    checked++;
                    if (m_hash_value !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("[%0t] hash_value mismatch: expected %08h actual %08h",
                                     $realtime, want, m_hash_value);
                    end
                end
            end

            // register write transaction
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HASH_MODE)
                    shadow_mode = cfg_data[MODE_W-1:0];
                else if (cfg_index == CFG_RESULT_OFFSET)
                    shadow_offset = cfg_data;
            end

            // key byte transaction
            if (s_valid && s_ready) begin
                seen[shadow_mode] = 1'b1;
                if (s_empty_key) begin
                    // zero-length key drops any partial key
                    mid_key = 1'b0;
                    empties++;
                    sum = key_seed(shadow_mode, s_key_length) + shadow_offset;
                    owed_hashes.push_back(sum);
                end else begin
                    if (!mid_key) begin
                        key_hash  = key_seed(shadow_mode, s_key_length);
                        odd_byte  = 1'b0;
                        rs_factor = RS_B_START;
                    end
                    key_hash  = fold_key_byte(shadow_mode, key_hash, s_key_byte, odd_byte,
                                              rs_factor);
                    odd_byte  = ~odd_byte;
                    rs_factor = rs_factor * RS_A;
                    folded++;
                    if (s_last_byte) begin
                        mid_key = 1'b0;
                        sum = key_hash + shadow_offset;
                        owed_hashes.push_back(sum);
                    end else begin
                        mid_key = 1'b1;
                    end
                end
            end
        end

        error_count    <= errors;
        pending_hashes <= owed_hashes.size();
        hashes_checked <= checked;
        bytes_folded   <= folded;
        empty_keys     <= empties;
        modes_seen     <= seen;
    end

endmodule

@@ sim/tb_multi_mode_string_hash.sv @@
// testbench top for the string hash: key byte stimulus, register phases and verdict
`timescale 1ns / 1ps

module tb_multi_mode_string_hash;
    import mmsh_pkg::*;

    // codes past the last scheme
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 4'd11;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 4'd15;

    localparam int PHASES         = 16;
    localparam int BYTES_PER_PHASE = 58;
    localparam int SETTLE_CYCLES   = 8;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PERIODIC
    } ready_pattern_e;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HASH_BITS-1:0] cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_key_byte;
    logic [KEY_LEN_W-1:0] s_key_length;
    logic                 s_last_byte;
    logic                 s_empty_key;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [HASH_BITS-1:0] m_hash_value;

    int                   error_count;
    int                   pending_hashes;
    int                   hashes_checked;
    int                   bytes_folded;
    int                   empty_keys;
    logic [15:0]          modes_seen;

    int                   burst_left = 0;
    int                   key_bytes_left = 0;
    logic [KEY_LEN_W-1:0] key_len_field = '0;

    int                   stall_count = 0;
    ready_pattern_e       stall_pattern = READY_ALWAYS;

    multi_mode_string_hash uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_byte   (s_key_byte),
        .s_key_length (s_key_length),
        .s_last_byte  (s_last_byte),
        .s_empty_key  (s_empty_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    mmsh_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_byte     (s_key_byte),
        .s_key_length   (s_key_length),
        .s_last_byte    (s_last_byte),
        .s_empty_key    (s_empty_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .error_count    (error_count),
        .pending_hashes (pending_hashes),
        .hashes_checked (hashes_checked),
        .bytes_folded   (bytes_folded),
        .empty_keys     (empty_keys),
        .modes_seen     (modes_seen)
    );

    // 250 MHz clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hash receiver back-pressure from a ready pattern that is picked anew at random
    always @(posedge aclk) begin
        stall_count <= stall_count + 1;
        if (stall_count % 50 == 0)
            stall_pattern <= ready_pattern_e'($urandom_range(0, 3));
        case (stall_pattern)
            READY_ALWAYS:   m_ready <= 1'b1;
            READY_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
            READY_RARELY:   m_ready <= ($urandom_range(0, 3) == 0);
            default:        m_ready <= ((stall_count % 8) < 5);
        endcase
    end

    // one key byte transaction, with bursts and random gaps in front
    task automatic send_item(input logic [7:0] key_byte, input logic [KEY_LEN_W-1:0] len,
                             input logic last, input logic empty);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_key_byte   <= key_byte;
        s_key_length <= len;
        s_last_byte  <= last;
        s_empty_key  <= empty;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender holds off until every owed hash is back and the pipe is empty
    task automatic wait_for_hashes();
        s_valid    <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge aclk);
        while (pending_hashes != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // scheme write, optionally followed by an offset write
    task automatic set_config(input logic [MODE_W-1:0] mode, input logic with_offset,
                              input hash_t offset);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HASH_MODE;
        cfg_data  <= hash_t'(mode);
        do @(posedge aclk); while (!cfg_ready);
        if (with_offset) begin
            cfg_index <= CFG_RESULT_OFFSET;
            cfg_data  <= offset;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // next byte of a random key stream: mostly short well-formed keys
    task automatic send_random_byte();
        int   roll;
        logic [7:0] key_byte;
        logic [KEY_LEN_W-1:0] len;
        roll = $urandom_range(0, 99);
        if (key_bytes_left == 0 && roll < 8) begin
            // zero-length key, byte and last mark don't matter
            send_item(8'($urandom_range(0, 255)), KEY_LEN_W'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)), 1'b1);
        end else if (key_bytes_left != 0 && roll < 2) begin
            // empty key cutting a partial key short
            key_bytes_left = 0;
            send_item(8'($urandom_range(0, 255)), KEY_LEN_W'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)), 1'b1);
        end else begin
            if (key_bytes_left == 0) begin
                key_bytes_left = (roll < 12) ? $urandom_range(13, 64) : $urandom_range(1, 12);
                key_len_field  = ($urandom_range(0, 7) == 0)
                                 ? KEY_LEN_W'($urandom_range(0, 65535))
                                 : KEY_LEN_W'(key_bytes_left);
            end
            case ($urandom_range(0, 9))
                0:       key_byte = 8'h00;
                1:       key_byte = 8'hFF;
                default: key_byte = 8'($urandom_range(0, 255));
            endcase
            len = ($urandom_range(0, 15) == 0) ? KEY_LEN_W'($urandom_range(0, 65535))
                                               : key_len_field;
            key_bytes_left--;
            send_item(key_byte, len, key_bytes_left == 0, 1'b0);
        end
    endtask

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [MODE_W-1:0] mode;
        logic              with_offset;
        hash_t             offset;
        aresetn      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_HASH_MODE;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_key_byte   <= '0;
        s_key_length <= '0;
        s_last_byte  <= 1'b0;
        s_empty_key  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // out of reset: ap scheme, zero offset, both byte parities
        send_item(8'h00, 16'd1, 1'b1, 1'b0);
        send_item(8'hFF, 16'hFFFF, 1'b0, 1'b0);
        send_item(8'h00, 16'hFFFF, 1'b1, 1'b0);
        send_item(8'h80, 16'd0, 1'b0, 1'b1);
        wait_for_hashes();

        // dek seeds from length; offset all ones wraps the sum
        set_config(MODE_DEK, 1'b1, 32'hFFFF_FFFF);
        send_item(8'h5A, 16'hFFFF, 1'b0, 1'b1);
        send_item(8'hFF, 16'h0000, 1'b0, 1'b0);
        send_item(8'h01, 16'hFFFF, 1'b1, 1'b0);
        // empty mark wins over last mark
        send_item(8'h33, 16'h1234, 1'b1, 1'b1);
        // partial key thrown away by an empty key, then a fresh key
        send_item(8'hC3, 16'h0002, 1'b0, 1'b0);
        send_item(8'h00, 16'h00FF, 1'b0, 1'b1);
        send_item(8'h7E, 16'h0001, 1'b1, 1'b0);
        wait_for_hashes();

        // scheme switched part-way through a key, no reload
        set_config(MODE_RS, 1'b1, 32'h0000_0000);
        send_item(8'hA5, 16'd3, 1'b0, 1'b0);
        send_item(8'hFF, 16'd3, 1'b0, 1'b0);
        wait_for_hashes();
        set_config(MODE_FNV, 1'b0, '0);
        send_item(8'h5A, 16'd3, 1'b1, 1'b0);
        wait_for_hashes();

        // spare scheme codes leave just the offset
        set_config(MODE_SPARE_LAST, 1'b1, 32'h1234_5678);
        send_item(8'hFF, 16'd2, 1'b0, 1'b0);
        send_item(8'h01, 16'd2, 1'b1, 1'b0);
        wait_for_hashes();
        set_config(MODE_SPARE_FIRST, 1'b0, '0);
        send_item(8'h00, 16'hFFFF, 1'b0, 1'b1);
        wait_for_hashes();

        // random phases: every scheme in turn, then random ones; keys may span phases
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_hashes();
            if (phase <= int'(MODE_SDBM))
                mode = MODE_W'(phase);
            else
                mode = MODE_W'($urandom_range(MODE_AP, MODE_SDBM));
            with_offset = (phase < 2) || (phase % 3 == 0);
            if (phase == 0)
                offset = '0;
            else if (phase == 1)
                offset = '1;
            else
                offset = $urandom();
            set_config(mode, with_offset, offset);
            repeat (BYTES_PER_PHASE) send_random_byte();
        end
        wait_for_hashes();

        $display("covered %0d key bytes and %0d empty keys, %0d hashes checked",
                 bytes_folded, empty_keys, hashes_checked);
        $display("scheme mask %04h, offsets zero, all ones and random, modes switched mid-key",
                 modes_seen);
        if (error_count == 0 && pending_hashes == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
